// ----- rtl/core/amef_pkg.sv -----
// shared types and constants of the approximate match end finder
`timescale 1ns / 1ps
`default_nettype none

package amef_pkg;

  localparam int DIST_W = 6;
  localparam int SYM_W  = 8;
  localparam int SLOT_W = 5;
  localparam int POS_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TEXT  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic {
    REG_MAX_DIST = 1'b0,
    REG_PAT_LEN  = 1'b1
  } reg_e;

  typedef struct packed {
    action_e           action;
    logic [SLOT_W-1:0] pattern_index;
    logic [SYM_W-1:0]  symbol;
  } in_item_t;

  typedef struct packed {
    logic              text_result;
    logic              is_match_end;
    logic [DIST_W-1:0] edit_distance;
    logic [POS_W-1:0]  text_position;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] max_distance;
    logic [DIST_W-1:0] pattern_length;
  } cfg_t;

  // one beat travelling down the row of cells
  typedef struct packed {
    logic              valid;
    logic              report;
    action_e           action;
    logic [SLOT_W-1:0] slot;
    logic [SYM_W-1:0]  sym;
  } token_t;

  // token plus the new and old distance of the row it just left
  typedef struct packed {
    token_t            tok;
    logic [DIST_W-1:0] dist_new;
    logic [DIST_W-1:0] dist_old;
  } stage_t;

endpackage

`default_nettype wire

// ----- rtl/core/amef_if.sv -----
// valid/ready channel interfaces for input beats and result beats
`timescale 1ns / 1ps
`default_nettype none

interface amef_in_if
  import amef_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface amef_out_if
  import amef_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/amef_cfg.sv -----
// apb register block for max distance and pattern length
`timescale 1ns / 1ps
`default_nettype none

module amef_cfg
  import amef_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;
  reg_e reg_sel;
  logic wr_en;

  assign reg_sel = reg_e'(paddr[ADDR_W-1]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_distance   <= '0;
      cfg_q.pattern_length <= DIST_W'(1);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_DIST: cfg_q.max_distance   <= pwdata[DIST_W-1:0];
        REG_PAT_LEN:  cfg_q.pattern_length <= pwdata[DIST_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_DIST: prdata = DATA_W'(cfg_q.max_distance);
      REG_PAT_LEN:  prdata = DATA_W'(cfg_q.pattern_length);
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/amef_cell.sv -----
// one row of the distance column with its pattern symbol
`timescale 1ns / 1ps
`default_nettype none

module amef_cell
  import amef_pkg::*;
#(
  parameter int ROW = 1
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire stage_t in_i,
  output stage_t      out_o
);

  localparam int DistMax = (1 << DIST_W) - 1;
  localparam int RowSat  = (ROW > DistMax) ? DistMax : ROW;
  localparam logic [DIST_W-1:0] RowInit = DIST_W'(RowSat);

  logic [DIST_W-1:0] val_q;
  logic [SYM_W-1:0]  pat_q;
  stage_t            out_q;

  logic [DIST_W-1:0] min_a;
  logic [DIST_W-1:0] min_b;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] nv;

  // diag = old value of row above, left = its new value, up = own value
  always_comb begin
    min_a = (in_i.dist_old < val_q) ? in_i.dist_old : val_q;
    min_b = (min_a < in_i.dist_new) ? min_a : in_i.dist_new;
    sum   = {1'b0, min_b} + (DIST_W+1)'(1);
    if (pat_q == in_i.tok.sym) begin
      nv = in_i.dist_old;
    end else begin
      nv = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= RowInit;
      out_q <= '0;
    end else if (en_i) begin
      out_q.tok      <= in_i.tok;
      out_q.dist_new <= nv;
      out_q.dist_old <= val_q;
      if (in_i.tok.valid) begin
        unique case (in_i.tok.action)
          ACT_TEXT:  val_q <= nv;
          ACT_CLEAR: val_q <= RowInit;
          ACT_LOAD:  ;
          ACT_NONE:  ;
        endcase
      end
    end
  end

  // pattern symbol, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (en_i && in_i.tok.valid && (in_i.tok.action == ACT_LOAD) &&
        (int'(in_i.tok.slot) == ROW - 1)) begin
      pat_q <= in_i.tok.sym;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/approx_match_end_finder.sv -----
// top level: systolic row of edit distance cells with result tap and apb registers
// path: each beat passes the entry register, cells 1 to m and the result register,
//   m = min(pattern_length, PATTERN_MAX); the tap sits after cell m of the row
// throughput: one beat per cycle unless the output stalls; all cells shift together
// reset: column row i holds i, text position zero, max_distance 0, pattern_length 1
// pattern symbols are undefined until loaded; no clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none

module approx_match_end_finder
  import amef_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  amef_in_if.sink                in_i,
  amef_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int TapW = $clog2(PATTERN_MAX + 1);

  cfg_t cfg_s;

  // whole row shifts together; it stalls only when the result register is full
  logic en;

  // stage 0 is the entry register and stands for row 0, whose distance is always zero
  stage_t stage0_q;
  stage_t stage_s   [PATTERN_MAX+1];
  stage_t cell_in_s [1:PATTERN_MAX];

  logic [TapW-1:0] tap_idx;
  stage_t          tap_s;

  logic             out_valid_q;
  out_item_t        out_q;
  out_item_t        out_d;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] pos_d;
  logic [POS_W-1:0] pos_inc;

  amef_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg_s)
  );

  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // entry register: every accepted beat becomes a token that owes one result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage0_q <= '0;
    end else if (en) begin
      stage0_q.tok.valid  <= in_i.valid;
      stage0_q.tok.report <= in_i.valid;
      stage0_q.tok.action <= in_i.data.action;
      stage0_q.tok.slot   <= in_i.data.pattern_index;
      stage0_q.tok.sym    <= in_i.data.symbol;
      stage0_q.dist_new   <= '0;
      stage0_q.dist_old   <= '0;
    end
  end

  assign stage_s[0] = stage0_q;

  // row of cells; a token loses its report flag once it has passed the tap,
  // so a later change of pattern length cannot deliver it twice
  for (genvar k = 1; k <= PATTERN_MAX; k++) begin : g_row
    always_comb begin
      cell_in_s[k] = stage_s[k-1];
      if (tap_idx == TapW'(k - 1)) begin
        cell_in_s[k].tok.report = 1'b0;
      end
    end

    amef_cell #(
      .ROW (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .in_i   (cell_in_s[k]),
      .out_o  (stage_s[k])
    );
  end

  // lengths past the row saturate at its last cell
  always_comb begin
    if (int'(cfg_s.pattern_length) > PATTERN_MAX) begin
      tap_idx = TapW'(PATTERN_MAX);
    end else begin
      tap_idx = TapW'(cfg_s.pattern_length);
    end
  end

  assign tap_s   = stage_s[tap_idx];
  assign pos_inc = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);

  // next result and text position; the position counts delivered text results in order
  always_comb begin
    out_d = '0;
    pos_d = pos_q;
    if (tap_s.tok.valid && tap_s.tok.report) begin
      unique case (tap_s.tok.action)
        ACT_TEXT: begin
          pos_d               = pos_inc;
          out_d.text_result   = 1'b1;
          out_d.is_match_end  = (tap_s.dist_new <= cfg_s.max_distance);
          out_d.edit_distance = tap_s.dist_new;
          out_d.text_position = pos_inc;
        end
        ACT_CLEAR: pos_d = '0;
        ACT_LOAD:  ;
        ACT_NONE:  ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
      pos_q       <= '0;
    end else if (en) begin
      out_valid_q <= tap_s.tok.valid && tap_s.tok.report;
      out_q       <= out_d;
      pos_q       <= pos_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // tap never points past the last cell
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(tap_idx) <= PATTERN_MAX)
    else $error("tap index beyond row");

  // results of non-text beats carry no distance, flag or position
  a_non_text_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.text_result) |->
      (!out_q.is_match_end && out_q.edit_distance == '0 && out_q.text_position == '0))
    else $error("non-text result not zero");

  // text positions are one-based
  a_text_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.text_result) |-> (out_q.text_position != '0))
    else $error("text position zero");

  // a stalled row keeps its entry token
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(stage0_q))
    else $error("entry token changed during stall");

endmodule

`default_nettype wire
